@@ design/ssnp_pkg.sv @@
package ssnp_pkg;

    // Window size and field widths.
    localparam int WIN_DEPTH  = 16;
    localparam int INDEX_BITS = 10;
    localparam int COORD_BITS = 16;
    localparam int DIST_BITS  = 15;

    // Ring addresses and counts that must also hold the full depth.
    localparam int ADDR_BITS = $clog2(WIN_DEPTH);
    localparam int CNT_BITS  = $clog2(WIN_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(WIN_DEPTH);

    // Reset value of the distance limit.
    localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(1600);

    // One stored point, index in the lowest bits.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_x;
        logic [INDEX_BITS-1:0]        idx;
    } win_entry_t;

    localparam int ENTRY_BITS = $bits(win_entry_t);

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_DATA_BITS  = ((ENTRY_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * INDEX_BITS + 1;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    // Modular add of a ring base and an offset below the depth.
    function automatic logic [ADDR_BITS-1:0] ring_add(input logic [ADDR_BITS-1:0] base,
                                                      input logic [ADDR_BITS-1:0] off);
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_BITS + 1)'(WIN_DEPTH)) begin
            sum = sum - (ADDR_BITS + 1)'(WIN_DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

@@ design/ssnp_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module ssnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sorted_sweep_neighbor_pairs.sv @@
// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tuser: frame_start; s_tdata: point, pos_x, pos_y
// m_        out        m_tvalid/m_tready   m_tuser: pair_valid; m_tdata: pair, m_tlast: last
// cfg_      in         cfg_valid/cfg_ready cfg_data: max_distance
//
// Each point is scanned against the stored points (count, at most 16) one entry per cycle
// through a three-stage test pipeline, then written into the window; its results are then
// emitted one per pair, or as a single one without a pair, before the next point is accepted.
// Reset clears the window, the distance limit returns to 1600 (Q11.4).
// A stalled result holds the output register; the next point is accepted once the
// last result of the current one has been loaded into it.
module sorted_sweep_neighbor_pairs (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input points.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ssnp_pkg::S_DATA_BITS-1:0]   s_tdata,   // point_index, pos_x, pos_y
    input  logic                               s_tuser,   // frame_start
    // Result pairs.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ssnp_pkg::M_DATA_BITS-1:0]   m_tdata,   // earlier_index, later_index,
                                                          // window_overflow
    output logic                               m_tuser,   // pair_valid
    output logic                               m_tlast,   // last_of_run
    // Distance limit register.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssnp_pkg::DIST_BITS-1:0]     cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam int AW = ssnp_pkg::ADDR_BITS;
    localparam int CW = ssnp_pkg::CNT_BITS;
    localparam int XW = ssnp_pkg::COORD_BITS;
    localparam int IW = ssnp_pkg::INDEX_BITS;
    localparam int DW = ssnp_pkg::DIST_BITS;

    // Control state.
    logic [1:0]    state_reg, state_next;
    logic [DW-1:0] max_dist_reg, max_dist_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] nh_reg, nh_next;
    logic [CW-1:0] ep_reg, ep_next;
    logic          p1_reg, p1_next;
    logic          p2_reg, p2_next;
    logic          p3_reg, p3_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;

    // Payload state.
    ssnp_pkg::win_entry_t new_entry_reg;
    logic [2*DW-1:0]      lim2_reg;
    logic [XW-1:0]        adx_reg, ady_reg;
    logic [IW-1:0]        idx2_reg, idx3_reg;
    logic [2*XW-1:0]      sqx_reg, sqy_reg;
    logic                 m_pair_reg;
    logic                 m_last_reg;
    logic                 m_ovf_reg;
    logic [IW-1:0]        m_earlier_reg;
    logic [IW-1:0]        m_later_reg;

    // RAM ports.
    logic                          win_we;
    logic [AW-1:0]                 win_waddr, win_raddr;
    logic [ssnp_pkg::ENTRY_BITS-1:0] win_wdata, win_rdata;
    logic                          hit_we;
    logic [IW-1:0]                 hit_rdata;

    // Combinational datapath.
    ssnp_pkg::win_entry_t in_entry;
    ssnp_pkg::win_entry_t rd_entry;
    logic signed [XW:0]   diff_x, diff_y, neg_x, neg_y, max_ext;
    logic                 survive;
    logic [XW-1:0]        adx_c, ady_c;
    logic [2*XW:0]        dist2;
    logic                 s_accept;
    logic                 out_load;
    logic                 fin_ovf;

    assign in_entry = ssnp_pkg::win_entry_t'(s_tdata[ssnp_pkg::ENTRY_BITS-1:0]);
    assign rd_entry = ssnp_pkg::win_entry_t'(win_rdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load = !m_valid_reg || m_tready;
    assign fin_ovf  = (wr_reg == ssnp_pkg::DEPTH_CNT);

    // First test stage: eviction check and absolute coordinate differences.
    always_comb begin
        diff_x  = $signed({new_entry_reg.pos_x[XW-1], new_entry_reg.pos_x})
                - $signed({rd_entry.pos_x[XW-1], rd_entry.pos_x});
        diff_y  = $signed({new_entry_reg.pos_y[XW-1], new_entry_reg.pos_y})
                - $signed({rd_entry.pos_y[XW-1], rd_entry.pos_y});
        neg_x   = -diff_x;
        neg_y   = -diff_y;
        max_ext = $signed((XW + 1)'(max_dist_reg));
        survive = !(diff_x > max_ext);
        adx_c   = diff_x[XW] ? neg_x[XW-1:0] : diff_x[XW-1:0];
        ady_c   = diff_y[XW] ? neg_y[XW-1:0] : diff_y[XW-1:0];
    end

    // Last test stage: squared distance against the squared limit.
    assign dist2  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hit_we = p3_reg && (dist2 < (2 * XW + 1)'(lim2_reg));

    // Window RAM addressing: scan reads, compacting writes, then the new point.
    always_comb begin
        win_raddr = ssnp_pkg::ring_add(base_reg, rd_reg[AW-1:0]);
        win_we    = 1'b0;
        win_waddr = ssnp_pkg::ring_add(base_reg, wr_reg[AW-1:0]);
        win_wdata = win_rdata;
        if (state_reg == ST_FINISH) begin
            win_we    = 1'b1;
            win_wdata = new_entry_reg;
            if (fin_ovf) begin
                win_waddr = base_reg;
            end
        end else if (p1_reg && survive) begin
            win_we = 1'b1;
        end
    end

    // Sequencer and output register control.
    always_comb begin
        state_next    = state_reg;
        max_dist_next = max_dist_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        nh_next       = nh_reg;
        ep_next       = ep_reg;
        p1_next       = 1'b0;
        p2_next       = p1_reg && survive;
        p3_next       = p2_reg;
        ovf_next      = ovf_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        if (cfg_valid && cfg_ready) begin
            max_dist_next = cfg_data;
        end
        if (p1_reg && survive) begin
            wr_next = wr_reg + 1'b1;
        end
        if (hit_we) begin
            nh_next = nh_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        count_next = '0;
                    end
                    rd_next    = '0;
                    wr_next    = '0;
                    nh_next    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_reg < count_reg) begin
                    rd_next = rd_reg + 1'b1;
                    p1_next = 1'b1;
                end else if (!p1_reg && !p2_reg && !p3_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                ovf_next = fin_ovf;
                if (fin_ovf) begin
                    count_next = ssnp_pkg::DEPTH_CNT;
                    base_next  = ssnp_pkg::ring_add(base_reg, AW'(1));
                end else begin
                    count_next = wr_reg + 1'b1;
                end
                ep_next    = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (nh_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        ep_next = ep_reg + 1'b1;
                        if (ep_reg + 1'b1 == nh_reg) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_dist_reg <= ssnp_pkg::DIST_RESET;
            count_reg    <= '0;
            base_reg     <= '0;
            rd_reg       <= '0;
            wr_reg       <= '0;
            nh_reg       <= '0;
            ep_reg       <= '0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            p3_reg       <= 1'b0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            max_dist_reg <= max_dist_next;
            count_reg    <= count_next;
            base_reg     <= base_next;
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
            nh_reg       <= nh_next;
            ep_reg       <= ep_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: captured point, test pipeline and output register.
    always_ff @(posedge aclk) begin
        lim2_reg <= (2 * DW)'(max_dist_reg) * (2 * DW)'(max_dist_reg);
        if (s_accept) begin
            new_entry_reg <= in_entry;
        end
        adx_reg  <= adx_c;
        ady_reg  <= ady_c;
        idx2_reg <= rd_entry.idx;
        sqx_reg  <= (2 * XW)'(adx_reg) * (2 * XW)'(adx_reg);
        sqy_reg  <= (2 * XW)'(ady_reg) * (2 * XW)'(ady_reg);
        idx3_reg <= idx2_reg;
        if (state_reg == ST_EMIT && out_load) begin
            m_later_reg <= new_entry_reg.idx;
            m_ovf_reg   <= ovf_reg;
            if (nh_reg == '0) begin
                m_pair_reg    <= 1'b0;
                m_earlier_reg <= '0;
                m_last_reg    <= 1'b1;
            end else begin
                m_pair_reg    <= 1'b1;
                m_earlier_reg <= hit_rdata;
                m_last_reg    <= (ep_reg + 1'b1 == nh_reg);
            end
        end
    end

    // Window of stored points.
    ssnp_ram #(
        .WIDTH (ssnp_pkg::ENTRY_BITS),
        .DEPTH (ssnp_pkg::WIN_DEPTH)
    ) u_win_ram (
        .clk   (aclk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // Indices of close points found during the scan; read one ahead of the output.
    ssnp_ram #(
        .WIDTH (IW),
        .DEPTH (ssnp_pkg::WIN_DEPTH)
    ) u_hit_ram (
        .clk   (aclk),
        .we    (hit_we),
        .waddr (nh_reg[AW-1:0]),
        .wdata (idx3_reg),
        .raddr (ep_next[AW-1:0]),
        .rdata (hit_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_pair_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = ssnp_pkg::M_DATA_BITS'({m_ovf_reg, m_later_reg, m_earlier_reg});

    // The window never holds more points than it has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ssnp_pkg::DEPTH_CNT)
        else $error("window count exceeds depth");

    // Compaction never writes an entry that the scan has not yet read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (wr_reg <= rd_reg))
        else $error("compaction write ahead of scan read");

    // Results are never read past the number of pairs found.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (ep_reg <= nh_reg))
        else $error("emit pointer past hit count");

    // A result without a pair is always the only and last one of its point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_pair_reg) |-> m_last_reg)
        else $error("empty result not marked last");

endmodule
